/* rtl/ce_pkg.sv */
// Shared codes for the combination enumerator.
package ce_pkg;
  localparam int MASK_W = 64;
  localparam int CNT_W = 7;
  localparam int RANK_W = 63;
  localparam int PROD_W = 71;

  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_JUMP = 1'b1;

  localparam logic REG_SET_SIZE = 1'b0;
  localparam logic REG_CHOOSE_COUNT = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

  typedef logic [MASK_W-1:0] mask_t;
endpackage

/* rtl/combination_enumerator_unit.sv */
// Combination enumerator: lexicographic advance and rank jump over a membership mask.
//
//  channel  dir  handshake          payload
//  in       in   in_valid/in_ready  in_action, in_rank
//  out      out  out_valid/out_ready out_member_mask, out_status
//  cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Advance: one mask bit scanned per cycle.
// Jump: each binomial step is a sequencing state (S_TOT or S_WALK), a multiply state (S_MUL)
//   and a bit-serial divide (S_DIV); up to 2n steps.
// in_ready is high only in idle; a finished result waits in the output register.
// Reset (rst_n, synchronous) gives n=MAX_SET, k=1 and the first combination.
module combination_enumerator_unit #(
  parameter int MAX_SET = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_action,
  input  logic [ce_pkg::RANK_W-1:0] in_rank,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ce_pkg::mask_t          out_member_mask,
  output logic [1:0]             out_status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [6:0]             cfg_data
);
  import ce_pkg::*;

  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_SET);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADV  = 4'd1;
  localparam logic [3:0] S_TOT  = 4'd2;
  localparam logic [3:0] S_WALK = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;

  localparam logic [1:0] PH_TOT = 2'd0;
  localparam logic [1:0] PH_A   = 2'd1;
  localparam logic [1:0] PH_B   = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, k_r, k_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [CNT_W-1:0] c_r, c_nxt, mop_r, mop_nxt, dv_r, dv_nxt, dcnt_r, dcnt_nxt;
  logic [1:0] ph_r, ph_nxt, status_r, status_nxt;
  mask_t mask_r, mask_nxt, cur_r, cur_nxt, x_r, x_nxt;
  logic [PROD_W-1:0] dq_r, dq_nxt;
  logic [CNT_W:0] rem_r, rem_nxt, rem_t;
  logic [CNT_W:0] rem_s;
  logic [5:0] idx_r, idx_nxt;
  logic seen_r, seen_nxt, valid_r, valid_nxt;
  logic out_valid_r, out_valid_nxt;
  mask_t out_mask_r, out_mask_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [CNT_W-1:0] pos_c;
  logic [CNT_W-1:0] cfg_n;

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_member_mask = out_mask_r;
  assign out_status = out_status_r;
  assign cfg_n = (cfg_data > MAX_N) ? MAX_N : cfg_data;
  assign pos_c = n_r - 7'd1 - a_r;
  assign rem_s = {rem_r[CNT_W-1:0], dq_r[PROD_W-1]};
  assign rem_t = rem_s - {1'b0, dv_r};

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    k_nxt = k_r;
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    mop_nxt = mop_r;
    dv_nxt = dv_r;
    dcnt_nxt = dcnt_r;
    ph_nxt = ph_r;
    status_nxt = status_r;
    mask_nxt = mask_r;
    cur_nxt = cur_r;
    x_nxt = x_r;
    dq_nxt = dq_r;
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    seen_nxt = seen_r;
    valid_nxt = valid_r;
    out_valid_nxt = out_valid_r;
    out_mask_nxt = out_mask_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid) begin
      if (cfg_index == REG_SET_SIZE) begin
        n_nxt = cfg_n;
        valid_nxt = (k_r <= cfg_n);
      end else begin
        k_nxt = cfg_data;
        valid_nxt = (cfg_data <= n_r);
      end
      mask_nxt = ~(~mask_t'(0) << k_nxt);
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_ADVANCE) begin
            if (!valid_r || k_r > n_r || k_r == 7'd0) begin
              status_nxt = ST_EXHAUSTED;
              state_nxt = S_FIN;
            end else begin
              idx_nxt = 6'(n_r - 7'd1);
              seen_nxt = 1'b0;
              c_nxt = '0;
              state_nxt = S_ADV;
            end
          end else if (k_r > n_r) begin
            valid_nxt = 1'b0;
            status_nxt = ST_OUT_OF_RANGE;
            state_nxt = S_FIN;
          end else begin
            x_nxt = {1'b0, in_rank};
            cur_nxt = mask_t'(1);
            a_nxt = k_r;
            mask_nxt = '0;
            state_nxt = S_TOT;
          end
        end
      end
      S_ADV: begin
        if (mask_r[idx_r] && seen_r) begin
          mask_nxt = (mask_r & ~(~mask_t'(0) << idx_r)) |
                     (~(~mask_t'(0) << (c_r + 7'd1)) << (idx_r + 6'd1));
          status_nxt = ST_OK;
          state_nxt = S_FIN;
        end else begin
          if (!mask_r[idx_r]) seen_nxt = 1'b1;
          else c_nxt = c_r + 7'd1;
          if (idx_r == 6'd0) begin
            status_nxt = ST_EXHAUSTED;
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r - 6'd1;
          end
        end
      end
      S_TOT: begin
        if (a_r == n_r) begin
          if (x_r >= cur_r) begin
            valid_nxt = 1'b0;
            status_nxt = ST_OUT_OF_RANGE;
            state_nxt = S_FIN;
          end else begin
            x_nxt = cur_r - 64'd1 - x_r;
            b_nxt = k_r;
            state_nxt = S_WALK;
          end
        end else begin
          mop_nxt = a_r + 7'd1;
          dv_nxt = a_r + 7'd1 - k_r;
          ph_nxt = PH_TOT;
          state_nxt = S_MUL;
        end
      end
      S_WALK: begin
        if (b_r == 7'd0) begin
          valid_nxt = 1'b1;
          status_nxt = ST_OK;
          state_nxt = S_FIN;
        end else if (a_r >= b_r && cur_r > x_r) begin
          mop_nxt = a_r - b_r;
          dv_nxt = a_r;
          ph_nxt = PH_A;
          state_nxt = S_MUL;
        end else begin
          mask_nxt = mask_r | (mask_t'(1) << pos_c[5:0]);
          x_nxt = x_r - cur_r;
          if (a_r + 7'd1 == b_r) begin
            cur_nxt = mask_t'(1);
            b_nxt = b_r - 7'd1;
          end else begin
            mop_nxt = b_r;
            dv_nxt = a_r - b_r + 7'd1;
            ph_nxt = PH_B;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        dq_nxt = PROD_W'(cur_r) * PROD_W'(mop_r);
        rem_nxt = '0;
        dcnt_nxt = 7'(PROD_W);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dcnt_r == 7'd0) begin
          cur_nxt = dq_r[MASK_W-1:0];
          case (ph_r)
            PH_TOT: begin
              a_nxt = a_r + 7'd1;
              state_nxt = S_TOT;
            end
            PH_A: begin
              a_nxt = a_r - 7'd1;
              state_nxt = S_WALK;
            end
            default: begin
              b_nxt = b_r - 7'd1;
              state_nxt = S_WALK;
            end
          endcase
        end else begin
          if (!rem_t[CNT_W]) begin
            rem_nxt = rem_t;
            dq_nxt = {dq_r[PROD_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_s;
            dq_nxt = {dq_r[PROD_W-2:0], 1'b0};
          end
          dcnt_nxt = dcnt_r - 7'd1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_mask_nxt = (valid_r && k_r <= n_r) ? mask_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r <= MAX_N;
      k_r <= 7'd1;
      mask_r <= mask_t'(1);
      valid_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;
      k_r <= k_nxt;
      mask_r <= mask_nxt;
      valid_r <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    mop_r <= mop_nxt;
    dv_r <= dv_nxt;
    dcnt_r <= dcnt_nxt;
    ph_r <= ph_nxt;
    status_r <= status_nxt;
    cur_r <= cur_nxt;
    x_r <= x_nxt;
    dq_r <= dq_nxt;
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
    seen_r <= seen_nxt;
    out_mask_r <= out_mask_nxt;
    out_status_r <= out_status_nxt;
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dv_r != 7'd0))
    else $error("divide by zero");
  a_out_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r != 2'd3))
    else $error("bad status");
  a_oor_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OUT_OF_RANGE) |-> (out_mask_r == '0))
    else $error("out of range with nonempty mask");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_ready)) |=> (state_r == S_IDLE && out_valid_r))
    else $error("result not posted");
endmodule
